// ===== rtl/core/sfd_pkg.sv =====
package sfd_pkg;

  localparam int unsigned FrameBytesDef = 8;
  localparam logic [7:0]  HeaderRst     = 8'hF0;
  localparam logic [6:0]  CsumMask      = 7'h7F;
  localparam int unsigned CmdBytes      = 3;

  localparam logic FuncByte  = 1'b0;
  localparam logic FuncFetch = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_CSUM_ERR = 2'd2,
    ST_REJECT   = 2'd3
  } status_e;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    status_e     frame_status;
    logic        cmd_valid;
    logic [23:0] cmd_value;
  } result_t;

endpackage

// ===== rtl/core/sfd_item_if.sv =====
interface sfd_item_if;
  logic              valid;
  logic              ready;
  sfd_pkg::item_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sfd_result_if.sv =====
interface sfd_result_if;
  logic              valid;
  logic              ready;
  sfd_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sfd_in_stage.sv =====
module sfd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  sfd_item_if.sink           s_item,
  input  logic               adv_i,
  output logic               vld_o,
  output sfd_pkg::item_t     item_o
);

  logic           vld_q, vld_d;
  sfd_pkg::item_t item_q;

  // take a new transfer whenever the held item is empty or moving on
  assign s_item.ready = !vld_q || adv_i;
  assign vld_d        = s_item.valid || (vld_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_item.valid && s_item.ready) begin
      item_q <= s_item.data;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== rtl/core/sfd_core.sv =====
module sfd_core #(
  parameter int unsigned FRAME_BYTES = sfd_pkg::FrameBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               step_i,
  input  sfd_pkg::item_t     item_i,
  output sfd_pkg::result_t   res_o
);

  localparam int unsigned PhW = $clog2(FRAME_BYTES);
  localparam logic [PhW-1:0] LastPhase = PhW'(FRAME_BYTES - 1);

  logic [7:0]     header_q;
  logic [PhW-1:0] phase_q, phase_d;
  logic [7:0]     sum_q, sum_d;
  logic [sfd_pkg::CmdBytes-1:0][7:0] held_q;
  logic [23:0]    latched_q, latched_d;
  logic           pending_q, pending_d;
  logic           data_byte;
  logic [7:0]     byte_b;

  assign byte_b = item_i.byte_value;

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    latched_d = latched_q;
    pending_d = pending_q;
    data_byte = 1'b0;
    res_o     = '{frame_status: sfd_pkg::ST_NONE, cmd_valid: 1'b0, cmd_value: 24'd0};
    if (item_i.func == sfd_pkg::FuncFetch) begin
      if (pending_q) begin
        res_o.cmd_valid = 1'b1;
        res_o.cmd_value = latched_q;
        pending_d       = 1'b0;
      end
    end else if (phase_q == '0) begin
      if (byte_b == header_q) begin
        sum_d   = 8'd0;
        phase_d = PhW'(1);
      end else begin
        res_o.frame_status = sfd_pkg::ST_REJECT;
      end
    end else if (phase_q < LastPhase) begin
      data_byte = 1'b1;
      sum_d     = sum_q + byte_b;
      phase_d   = phase_q + PhW'(1);
    end else if (phase_q == LastPhase) begin
      if (byte_b == {1'b0, sum_q[6:0] & sfd_pkg::CsumMask}) begin
        latched_d          = held_q;
        pending_d          = 1'b1;
        res_o.frame_status = sfd_pkg::ST_ACCEPT;
        res_o.cmd_value    = held_q;
      end else begin
        res_o.frame_status = sfd_pkg::ST_CSUM_ERR;
      end
      phase_d = '0;
      sum_d   = 8'd0;
    end else begin
      // unreachable phase: fall back to header hunt
      phase_d = '0;
      sum_d   = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= sfd_pkg::HeaderRst;
      phase_q   <= '0;
      sum_q     <= 8'd0;
      latched_q <= 24'd0;
      pending_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q   <= phase_d;
        sum_q     <= sum_d;
        latched_q <= latched_d;
        pending_q <= pending_d;
      end
    end
  end

  // capture command bytes 1..3 as they arrive
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < sfd_pkg::CmdBytes; k++) begin
      if (step_i && data_byte && phase_q == PhW'(k + 1)) begin
        held_q[k] <= byte_b;
      end
    end
  end

  a_phase_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= LastPhase)
    else $error("frame phase beyond last byte");

  a_accept_latch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.frame_status == sfd_pkg::ST_ACCEPT
      |=> pending_q && latched_q == $past(res_o.cmd_value))
    else $error("accepted frame not latched as pending");

  a_fetch_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.func == sfd_pkg::FuncFetch |=> !pending_q)
    else $error("fetch left command pending");

  a_reject_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.frame_status == sfd_pkg::ST_REJECT |=> phase_q == '0)
    else $error("rejected byte moved frame phase");

endmodule

// ===== rtl/core/sfd_out_stage.sv =====
module sfd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sfd_pkg::result_t   res_i,
  output logic               room_o,
  sfd_result_if.source       m_result
);

  logic             vld_q;
  sfd_pkg::result_t res_q;

  // room when empty or the waiting result leaves this cycle
  assign room_o = !vld_q || m_result.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (room_o) begin
      vld_q <= step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_i;
    end
  end

  assign m_result.valid = vld_q;
  assign m_result.data  = res_q;

endmodule

// ===== rtl/core/status_frame_deframer_top.sv =====
// Status frame deframer. Received bytes (func = 0) are searched for a frame of
// FRAME_BYTES bytes opening with the header byte held in the configuration
// register (0xF0 after reset); the last byte must equal the 8-bit sum of the
// data bytes masked to 7 bits. A good frame latches data bytes 1..3 (byte 1 in
// bits 7..0) as the pending command, replacing any unfetched one; a fetch item
// (func = 1) returns and clears it. Every item gives exactly one result. An
// item passes an input register and a result register. While the result
// side is ready, one item per cycle is sustained, as the frame phase, running
// sum and command registers update as each item steps. Ready depends
// combinationally on the result ready through both stages.
module status_frame_deframer_top #(
  parameter int unsigned FRAME_BYTES = sfd_pkg::FrameBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  sfd_item_if.sink      s_item,
  sfd_result_if.source  m_result
);

  logic             in_vld;
  sfd_pkg::item_t   item;
  sfd_pkg::result_t res;
  logic             room;
  logic             step;

  assign step = in_vld && room;

  sfd_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s_item (s_item),
    .adv_i  (step),
    .vld_o  (in_vld),
    .item_o (item)
  );

  sfd_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_o       (res)
  );

  sfd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .res_i    (res),
    .room_o   (room),
    .m_result (m_result)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DATA_BYTES = sfd_pkg::FrameBytesDef - 2;

  // Tracks the deframer state and queues the result that each item must give.
  class deframer_scoreboard;
    logic [7:0]       header;
    int unsigned      phase;
    logic [7:0]       run_sum;
    logic [23:0]      held;
    logic [23:0]      latched;
    bit               cmd_pending;
    sfd_pkg::result_t due_results[$];
    int unsigned      err_count;

    function new();
      header      = sfd_pkg::HeaderRst;
      phase       = 0;
      run_sum     = '0;
      held        = '0;
      latched     = '0;
      cmd_pending = 1'b0;
      err_count   = 0;
    endfunction

    function void set_header(logic [7:0] value);
      header = value;
    endfunction

    function void note_item(sfd_pkg::item_t it);
      sfd_pkg::result_t r;
      r.frame_status = sfd_pkg::ST_NONE;
      r.cmd_valid    = 1'b0;
      r.cmd_value    = '0;
      if (it.func == sfd_pkg::FuncFetch) begin
        if (cmd_pending) begin
          r.cmd_valid = 1'b1;
          r.cmd_value = latched;
          cmd_pending = 1'b0;
        end
      end else if (phase == 0) begin
        if (it.byte_value == header) begin
          run_sum = '0;
          phase   = 1;
        end else begin
          r.frame_status = sfd_pkg::ST_REJECT;
        end
      end else if (phase < sfd_pkg::FrameBytesDef - 1) begin
        run_sum = run_sum + it.byte_value;
        if (phase <= sfd_pkg::CmdBytes) held[(phase - 1) * 8 +: 8] = it.byte_value;
        phase++;
      end else begin
        // checksum byte must match in all 8 bits, so bit 7 set always fails
        if (it.byte_value == {1'b0, run_sum[6:0]}) begin
          latched        = held;
          cmd_pending    = 1'b1;
          r.frame_status = sfd_pkg::ST_ACCEPT;
          r.cmd_value    = held;
        end else begin
          r.frame_status = sfd_pkg::ST_CSUM_ERR;
        end
        phase   = 0;
        run_sum = '0;
      end
      due_results.push_back(r);
    endfunction

    function void check_result(sfd_pkg::result_t got);
      sfd_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result with no item outstanding: frame_status %0d cmd_valid %0d cmd_value %h",
               got.frame_status, got.cmd_valid, got.cmd_value);
        err_count++;
        return;
      end
      want = due_results.pop_front();
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
        err_count++;
      end
      if (got.cmd_valid !== want.cmd_valid) begin
        $error("cmd_valid: expected %0d, got %0d", want.cmd_valid, got.cmd_valid);
        err_count++;
      end
      if (got.cmd_value !== want.cmd_value) begin
        $error("cmd_value: expected %h, got %h", want.cmd_value, got.cmd_value);
        err_count++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  sfd_item_if   item_bus ();
  sfd_result_if result_bus ();

  status_frame_deframer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_item      (item_bus),
    .m_result    (result_bus)
  );

  deframer_scoreboard sb;
  bit                 idle_on;
  int unsigned        sent_items;
  logic [7:0]         frame_data [DATA_BYTES];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

  // Note each transfer on both channels; inputs first so the queue is current.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_bus.valid && item_bus.ready) sb.note_item(item_bus.data);
      if (result_bus.valid && result_bus.ready) sb.check_result(result_bus.data);
    end
  end

  initial begin : result_ready_gen
    int unsigned stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!idle_on) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      if (stall_left != 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Leaves valid high after the transfer; the caller drops it when done.
  task automatic send_item(input logic func, input logic [7:0] value);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.data  <= {func, value};
    do @(posedge clk_i); while (!item_bus.ready);
    sent_items++;
  endtask

  // Send header, frame_data and checksum, with a fetch before frame_data[fetch_at]; flip corrupts the checksum.
  task automatic send_frame(input logic [7:0] flip, input int fetch_at);
    logic [7:0] csum;
    csum = '0;
    send_item(sfd_pkg::FuncByte, sb.header);
    for (int i = 0; i < DATA_BYTES; i++) begin
      if (i == fetch_at) send_item(sfd_pkg::FuncFetch, 8'($urandom));
      send_item(sfd_pkg::FuncByte, frame_data[i]);
      csum = csum + frame_data[i];
    end
    send_item(sfd_pkg::FuncByte, {1'b0, csum[6:0]} ^ flip);
  endtask

  task automatic fill_random_frame();
    for (int i = 0; i < DATA_BYTES; i++)
      frame_data[i] = ($urandom_range(0, 7) == 0) ? sb.header : 8'($urandom);
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_header(value);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    logic [7:0]  flip;
    target = sent_items + count;
    while (sent_items < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(sfd_pkg::FuncByte, 8'($urandom));
      end else if (pick == 1) begin
        send_item(sfd_pkg::FuncFetch, 8'($urandom));
      end else if (pick == 2) begin
        // truncated frame: whatever follows is taken as its remaining bytes
        send_item(sfd_pkg::FuncByte, sb.header);
        repeat ($urandom_range(1, DATA_BYTES)) send_item(sfd_pkg::FuncByte, 8'($urandom));
      end else begin
        fill_random_frame();
        flip = ($urandom_range(0, 2) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
        send_frame(flip, ($urandom_range(0, 3) == 0) ? $urandom_range(0, DATA_BYTES - 1) : -1);
      end
    end
  endtask

  initial begin
    sb         = new();
    idle_on    = 1'b1;
    sent_items = 0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    item_bus.valid <= 1'b0;
    item_bus.data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fetch with nothing pending, then a stray byte outside a frame
    send_item(sfd_pkg::FuncFetch, 8'hFF);
    send_item(sfd_pkg::FuncByte, 8'h00);
    // good frame carrying the header value and both byte extremes as data
    frame_data[0] = 8'hFF;
    frame_data[1] = sfd_pkg::HeaderRst;
    frame_data[2] = 8'h00;
    for (int i = 3; i < DATA_BYTES; i++) frame_data[i] = i[0] ? 8'h80 : 8'h7F;
    send_frame(8'h00, -1);
    // second good frame overwrites; a fetch inside it returns the first
    fill_random_frame();
    send_frame(8'h00, 2);
    // checksum differing only in bit 7
    fill_random_frame();
    send_frame(8'h80, -1);
    send_item(sfd_pkg::FuncFetch, 8'h00);

    run_random(150);
    write_header(8'h00);
    run_random(150);
    write_header(8'hFF);
    run_random(150);
    write_header(8'($urandom));
    run_random(150);
    write_header(8'($urandom));
    idle_on = 1'b0;
    run_random(150);

    drain();
    if (sb.err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sfd_pkg.sv
rtl/core/sfd_item_if.sv
rtl/core/sfd_result_if.sv
rtl/core/sfd_in_stage.sv
rtl/core/sfd_core.sv
rtl/core/sfd_out_stage.sv
rtl/core/status_frame_deframer_top.sv
tb/testbench.sv
